[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent checks, used by hfcd_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

// Same-cycle implication that also holds through reset
`define ASSERT_ALWAYS(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

[sv/hfcd_pkg.sv]
// ---------------------------------------------------------------------------
// hfcd_pkg
// Types, constants and the byte-wide CRC-16 fold for the frame decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hfcd_pkg;

	// Position of a byte within the eight-byte sensor frame
	typedef logic [2:0] pos_t;

	localparam pos_t POS_FIRST  = 3'd0;
	localparam pos_t POS_HUM_HI = 3'd2;
	localparam pos_t POS_HUM_LO = 3'd3;
	localparam pos_t POS_TMP_HI = 3'd4;
	localparam pos_t POS_TMP_LO = 3'd5;
	localparam pos_t POS_CRC_LO = 3'd6;
	localparam pos_t POS_CRC_HI = 3'd7;

	// Bytes folded into the CRC: positions below this one
	localparam pos_t CRC_BYTES = 3'd6;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Fold one byte into a reflected CRC-16, least significant bit first
	function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[sv/humidity_frame_crc_decoder.sv]
// ---------------------------------------------------------------------------
// humidity_frame_crc_decoder
// Checks eight-byte sensor frames with CRC-16 and reports the last good
// humidity and temperature once per frame.
// ---------------------------------------------------------------------------
// The block takes one frame byte per cycle on the slave stream and gives
// one result per frame. Each byte passes an input register, one byte-wide
// CRC fold and the field capture logic, then the result register, so a
// result is loaded into the result register when its closing byte
// leaves the input register. The only stall is a held result: while a
// result waits on the master side, bytes that close no frame keep
// flowing, and a closing byte waits in the input register.
// tuser on the input marks byte 0 of a frame and drops any partial frame;
// without it, frames follow each other every eight bytes. After a CRC
// mismatch the result repeats the previously kept values with crc_ok low.
`timescale 1ns / 1ps
`default_nettype none

module humidity_frame_crc_decoder
	import hfcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  wire logic        s_axis_tuser,  // [0] frame_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [15:0] humidity_tenths, [31:16] temperature_tenths
	output logic             m_axis_tuser   // [0] crc_ok
);

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	// Frame state
	pos_t        pos_q;
	logic [15:0] crc_q;
	logic [15:0] cap_hum_q;
	logic [15:0] cap_tmp_q;
	logic [7:0]  crc_lo_q;
	logic [15:0] good_hum_q;
	logic signed [15:0] good_tmp_q;

	// Result register
	logic        out_valid_q;
	logic [15:0] out_hum_q;
	logic signed [15:0] out_tmp_q;
	logic        out_ok_q;

	// Combinational
	pos_t        pos_eff;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic        frame_end;
	logic        crc_match;
	logic [14:0] tmp_mag;
	logic signed [15:0] tmp_conv;
	logic        out_blocked;
	logic        advance;

	// Work out what the byte in the input register does
	always_comb begin
		pos_eff   = start_s1 ? POS_FIRST : pos_q;
		crc_base  = start_s1 ? CRC_INIT : crc_q;
		crc_next  = crc16_fold_byte(crc_base, byte_s1);
		frame_end = (pos_eff == POS_CRC_HI);
		crc_match = ({byte_s1, crc_lo_q} == crc_base);
		tmp_mag   = cap_tmp_q[14:0];
		if (cap_tmp_q[15]) begin
			tmp_conv = signed'(16'(~{1'b0, tmp_mag} + 16'd1));
		end else begin
			tmp_conv = signed'({1'b0, tmp_mag});
		end
	end

	// Hold a closing item only while the result register is still occupied
	assign out_blocked   = out_valid_q && !m_axis_tready;
	assign advance       = valid_s1 && (!frame_end || !out_blocked);
	assign s_axis_tready = !valid_s1 || advance;

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Advance the frame position, CRC and captured fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_FIRST;
			crc_q      <= CRC_INIT;
			cap_hum_q  <= '0;
			cap_tmp_q  <= '0;
			crc_lo_q   <= '0;
			good_hum_q <= '0;
			good_tmp_q <= '0;
		end else if (advance) begin
			if (frame_end) begin
				pos_q <= POS_FIRST;
				crc_q <= CRC_INIT;
				if (crc_match) begin
					good_hum_q <= cap_hum_q;
					good_tmp_q <= tmp_conv;
				end
			end else begin
				pos_q <= pos_t'(pos_eff + 3'd1);
				crc_q <= (pos_eff < CRC_BYTES) ? crc_next : crc_base;
			end
			case (pos_eff)
				POS_HUM_HI: cap_hum_q[15:8] <= byte_s1;
				POS_HUM_LO: cap_hum_q[7:0]  <= byte_s1;
				POS_TMP_HI: cap_tmp_q[15:8] <= byte_s1;
				POS_TMP_LO: cap_tmp_q[7:0]  <= byte_s1;
				POS_CRC_LO: crc_lo_q        <= byte_s1;
				default: ;
			endcase
		end
	end

	// Load the result register at the end of a frame, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end) begin
			out_ok_q  <= crc_match;
			out_hum_q <= crc_match ? cap_hum_q : good_hum_q;
			out_tmp_q <= crc_match ? tmp_conv : good_tmp_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_tmp_q, out_hum_q};
	assign m_axis_tuser  = out_ok_q;

endmodule

`default_nettype wire

[sv/hfcd_checker.sv]
// ---------------------------------------------------------------------------
// hfcd_checker
// Port-level checks for the frame decoder, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hfcd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	logic [31:0] last_q;
	logic        in_seen;

	// Track the payload of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			last_q <= m_axis_tdata;
		end
	end

	assign in_seen = s_axis_tvalid || s_axis_tuser || (s_axis_tdata != 8'h00);

	// A waiting result stays offered and unchanged
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// A failed frame repeats the kept values
	`ASSERT_SAME(a_fail_keeps, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == last_q)
	// With no result pending, input is never refused
	`ASSERT_ALWAYS(a_ready_free, clk, !m_axis_tvalid, s_axis_tready || !in_seen || s_axis_tready)

endmodule

bind humidity_frame_crc_decoder hfcd_checker u_hfcd_checker (.*);

`default_nettype wire

[bench/hfcd_reading_checker.sv]
// ---------------------------------------------------------------------------
// hfcd_reading_checker
// Watches both streams of the frame decoder, predicts each per-frame reading
// from the bytes taken in and compares every result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfcd_reading_checker
	import hfcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  wire logic        s_axis_tuser,  // [0] frame_start
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,  // [15:0] humidity_tenths, [31:16] temperature_tenths
	input  wire logic        m_axis_tuser,  // [0] crc_ok
	output int               mismatches,
	output int               readings_due
);

	typedef struct packed {
		logic [15:0] humidity;
		logic [15:0] temperature;
		logic        crc_ok;
	} reading_t;

	// Readings predicted from closing bytes, oldest first
	reading_t    reading_queue[$];

	// Shadow of the decoder state
	pos_t        next_pos;
	logic [15:0] frame_crc;
	logic [15:0] hum_capture;
	logic [15:0] tmp_capture;
	logic [7:0]  crc_low_byte;
	logic [15:0] kept_humidity;
	logic [15:0] kept_temperature;

	// Reflected CRC-16 over one byte, least significant bit first
	function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] acc;
		acc = crc ^ {8'h00, data};
		repeat (8) begin
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		return acc;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 200) begin
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		end
		mismatches++;
	endtask

	// Advance the shadow state by one byte; queue a reading on a closing byte
	task automatic track_byte(input logic [7:0] data, input logic start);
		pos_t        pos;
		logic [15:0] magnitude;
		logic        match;
		reading_t    reading;
		if (start) begin
			next_pos  = POS_FIRST;
			frame_crc = CRC_INIT;
		end
		pos = next_pos;
		if (pos < CRC_BYTES) begin
			frame_crc = crc_after_byte(frame_crc, data);
		end
		case (pos)
			POS_HUM_HI: hum_capture[15:8] = data;
			POS_HUM_LO: hum_capture[7:0]  = data;
			POS_TMP_HI: tmp_capture[15:8] = data;
			POS_TMP_LO: tmp_capture[7:0]  = data;
			POS_CRC_LO: crc_low_byte      = data;
			default: ;
		endcase
		if (pos != POS_CRC_HI) begin
			next_pos = pos + 3'd1;
		end else begin
			match = ({data, crc_low_byte} == frame_crc);
			if (match) begin
				// Sign and magnitude to two's complement; negative zero gives zero
				magnitude     = {1'b0, tmp_capture[14:0]};
				kept_humidity = hum_capture;
				kept_temperature = tmp_capture[15] ? 16'(16'd0 - magnitude) : magnitude;
			end
			reading.humidity    = kept_humidity;
			reading.temperature = kept_temperature;
			reading.crc_ok      = match;
			reading_queue.push_back(reading);
			next_pos  = POS_FIRST;
			frame_crc = CRC_INIT;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		if (!arst_n) begin
			reading_queue.delete();
			next_pos         = POS_FIRST;
			frame_crc        = CRC_INIT;
			hum_capture      = '0;
			tmp_capture      = '0;
			crc_low_byte     = '0;
			kept_humidity    = '0;
			kept_temperature = '0;
			mismatches       = 0;
			readings_due    <= 0;
		end else begin
			// Compare a result taken at this edge with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (reading_queue.size() == 0) begin
					report_mismatch("result with no frame closed", {m_axis_tdata}, '0);
				end else begin
					want = reading_queue.pop_front();
					if (m_axis_tdata[15:0] !== want.humidity) begin
						report_mismatch("humidity_tenths", 32'(m_axis_tdata[15:0]),
							32'(want.humidity));
					end
					if (m_axis_tdata[31:16] !== want.temperature) begin
						report_mismatch("temperature_tenths", 32'(m_axis_tdata[31:16]),
							32'(want.temperature));
					end
					if (m_axis_tuser !== want.crc_ok) begin
						report_mismatch("crc_ok", 32'(m_axis_tuser), 32'(want.crc_ok));
					end
				end
			end
			// Predict from a byte taken at this edge
			if (s_axis_tvalid && s_axis_tready) begin
				track_byte(s_axis_tdata, s_axis_tuser);
			end
			readings_due <= reading_queue.size();
		end
	end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the humidity frame CRC decoder.
// ---------------------------------------------------------------------------
// Sends a few hand-built frames (value extremes, negative zero, a CRC error,
// an abandoned partial frame, back-to-back frames with no marker), then
// random frames, mostly well formed, mixed with corrupted, cut-short and
// noise bytes. Three phases vary the idling of sender and receiver; the
// checker beside the block predicts and compares every reading.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import hfcd_pkg::*;

	localparam int BYTES_PER_PHASE = 670;
	localparam int STALL_LIMIT     = 4000;
	localparam int TAIL_CYCLES     = 16;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;  // [7:0] rx_byte
	logic        s_axis_tuser  = 1'b0;  // [0] frame_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // [15:0] humidity_tenths, [31:16] temperature_tenths
	logic        m_axis_tuser;  // [0] crc_ok

	int   mismatches;
	int   readings_due;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   bytes_sent  = 0;
	int   stall_count = 0;
	pos_t sent_pos    = POS_FIRST;

	humidity_frame_crc_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	hfcd_reading_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.mismatches   (mismatches),
		.readings_due (readings_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: take results, stalling at the current rate
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_count <= 0;
			end else begin
				stall_count <= stall_count + 1;
			end
			if (stall_count >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Offer one byte, idling first at the current rate, and hold until taken
	task automatic push_byte(input logic [7:0] data, input logic start);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		sent_pos = start ? 3'd1 : sent_pos + 3'd1;
		bytes_sent++;
	endtask

	// Hold the sender until every predicted reading has been taken
	task automatic drain_readings();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (readings_due != 0) begin
			@(posedge clk);
		end
	endtask

	// Build a frame with a correct CRC, optionally flip one bit, send the
	// first keep bytes; a marker is forced when the decoder is mid-frame
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [15:0] hum, input logic [15:0] temp, input logic marker,
			input int flip_at, input int keep);
		logic [7:0]  fr [8];
		logic [15:0] crc;
		crc   = CRC_INIT;
		fr[0] = addr;
		fr[1] = func;
		fr[2] = hum[15:8];
		fr[3] = hum[7:0];
		fr[4] = temp[15:8];
		fr[5] = temp[7:0];
		for (int i = 0; i < 6; i++) begin
			crc = crc16_fold_byte(crc, fr[3'(i)]);
		end
		fr[6] = crc[7:0];
		fr[7] = crc[15:8];
		if (flip_at >= 0) begin
			fr[3'(flip_at)] = fr[3'(flip_at)] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (int i = 0; i < keep; i++) begin
			push_byte(fr[3'(i)], (i == 0) && (marker || (sent_pos != POS_FIRST)));
		end
	endtask

	// Field value leaning on the edges of the range
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random mix of frames until the phase's byte budget is spent
	task automatic random_phase(input int tx_pct, input int rx_pct);
		int stop_at;
		int pick;
		stop_at     = bytes_sent + BYTES_PER_PHASE;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(8'($urandom), 8'($urandom), pick_word(), pick_word(),
					1'($urandom), -1, 8);
			end else if (pick < 80) begin
				send_frame(8'($urandom), 8'($urandom), pick_word(), pick_word(),
					1'($urandom), $urandom_range(0, 7), 8);
			end else if (pick < 90) begin
				send_frame(8'($urandom), 8'($urandom), pick_word(), pick_word(),
					1'($urandom), -1, $urandom_range(1, 7));
			end else begin
				repeat ($urandom_range(1, 10)) begin
					push_byte(8'($urandom), $urandom_range(0, 7) == 0);
				end
			end
		end
		drain_readings();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: full-scale humidity with the most negative temperature
		send_frame(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, -1, 8);
		// Back-to-back with no marker: zero humidity, negative zero
		send_frame(8'hFF, 8'h00, 16'h0000, 16'h8000, 1'b0, -1, 8);
		// Partial frame abandoned by a marker, then a CRC error on top temp
		send_frame(8'h5A, 8'h03, 16'h1234, 16'h0123, 1'b0, -1, 3);
		send_frame(8'hA5, 8'h03, 16'h0258, 16'h7FFF, 1'b1, 7, 8);
		drain_readings();

		random_phase(19, 75);
		random_phase(75, 19);
		random_phase(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && readings_due == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
